FILE: rtl/core/mpm_pkg.sv
package mpm_pkg;

  // Default width of the tick counter, excluding its saturation guard bit.
  localparam int COUNT_BITS_DEF = 24;

  localparam int PERIOD_W  = 10;
  localparam int TIMEOUT_W = 24;
  localparam int LIMIT_W   = 24;
  localparam int TICKS_W   = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METAL_LIMIT  = 2'd2;

  localparam logic [PERIOD_W-1:0]  PERIOD_COUNT_RST = 10'd100;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST      = 24'd10000000;
  localparam logic [LIMIT_W-1:0]   METAL_LIMIT_RST  = 24'd34188;

  typedef struct packed {
    logic start_req;
    logic pin_level;
  } mpm_in_t;

  typedef struct packed {
    logic [TICKS_W-1:0] period_ticks;
    logic               timed_out;
    logic               metal_found;
  } mpm_out_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]  period_count;
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [LIMIT_W-1:0]   metal_count_limit;
  } mpm_cfg_t;

endpackage

FILE: rtl/core/mpm_cfg.sv
module mpm_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpm_pkg::CFG_W-1:0]          cfg_data,
  output mpm_pkg::mpm_cfg_t                  cfg
);

  // Writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_count      <= mpm_pkg::PERIOD_COUNT_RST;
      cfg.timeout_ticks     <= mpm_pkg::TIMEOUT_RST;
      cfg.metal_count_limit <= mpm_pkg::METAL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mpm_pkg::REG_PERIOD_COUNT: cfg.period_count <= cfg_data[mpm_pkg::PERIOD_W-1:0];
        mpm_pkg::REG_TIMEOUT:      cfg.timeout_ticks <= cfg_data[mpm_pkg::TIMEOUT_W-1:0];
        mpm_pkg::REG_METAL_LIMIT:  cfg.metal_count_limit <= cfg_data[mpm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/mpm_core.sv
module mpm_core #(
  parameter int COUNT_BITS = mpm_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  mpm_pkg::mpm_in_t   item,
  input  mpm_pkg::mpm_cfg_t  cfg,
  output logic               push,
  output mpm_pkg::mpm_out_t  result
);

  localparam int CntW = COUNT_BITS + 1;
  localparam int CmpW = (CntW > mpm_pkg::LIMIT_W) ? CntW : mpm_pkg::LIMIT_W;
  localparam int PW   = mpm_pkg::PERIOD_W;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_LOW  = 3'd1,
    PH_WAIT_HIGH = 3'd2,
    PH_MEAS_LOW  = 3'd3,
    PH_MEAS_HIGH = 3'd4
  } phase_t;

  phase_t          phase, phase_next;
  logic [CntW-1:0] tick_count, tick_count_next;
  logic [PW-1:0]   periods_done, periods_done_next;

  logic [CntW-1:0]       tick_inc;
  logic [PW-1:0]         pd_inc;
  logic                  met;
  logic                  fin;
  logic                  tmo;
  logic [CntW-1:0]       fin_ticks;
  logic [COUNT_BITS-1:0] sat_ticks;

  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign pd_inc   = (periods_done == '1) ? periods_done : periods_done + 1'b1;
  assign met = (phase == PH_WAIT_LOW || phase == PH_MEAS_LOW) ? !item.pin_level
                                                              : item.pin_level;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    periods_done_next = periods_done;
    fin               = 1'b0;
    tmo               = 1'b0;
    fin_ticks         = '0;
    if (item.start_req) begin
      phase_next        = PH_WAIT_LOW;
      tick_count_next   = '0;
      periods_done_next = '0;
    end else begin
      case (phase)
        PH_WAIT_LOW, PH_WAIT_HIGH, PH_MEAS_LOW, PH_MEAS_HIGH: begin
          tick_count_next = tick_inc;
          if (met) begin
            case (phase)
              PH_WAIT_LOW: begin
                phase_next      = PH_WAIT_HIGH;
                tick_count_next = '0;
              end
              PH_WAIT_HIGH: begin
                tick_count_next   = '0;
                periods_done_next = '0;
                if (cfg.period_count == '0) begin
                  fin = 1'b1;
                end else begin
                  phase_next = PH_MEAS_LOW;
                end
              end
              PH_MEAS_LOW: begin
                phase_next = PH_MEAS_HIGH;
              end
              default: begin
                periods_done_next = pd_inc;
                phase_next        = PH_MEAS_LOW;
                if (pd_inc >= cfg.period_count) begin
                  fin       = 1'b1;
                  fin_ticks = tick_inc;
                end
              end
            endcase
          end else if (CmpW'(tick_inc) > CmpW'(cfg.timeout_ticks)) begin
            tmo = 1'b1;
          end
          if (fin || tmo) begin
            phase_next        = PH_IDLE;
            tick_count_next   = '0;
            periods_done_next = '0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Totals beyond the counter range report as all ones.
  assign sat_ticks = fin_ticks[CntW-1] ? '1 : fin_ticks[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      periods_done <= '0;
    end else if (take) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      periods_done <= periods_done_next;
    end
  end

  assign push                = take && (fin || tmo);
  assign result.period_ticks = mpm_pkg::TICKS_W'(sat_ticks);
  assign result.timed_out    = tmo;
  assign result.metal_found  = fin && (CmpW'(fin_ticks) < CmpW'(cfg.metal_count_limit));

endmodule

FILE: rtl/core/mpm_obuf.sv
module mpm_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mpm_pkg::mpm_out_t  push_data,
  output logic               room,
  output logic               res_valid,
  input  logic               res_ready,
  output mpm_pkg::mpm_out_t  res_data
);

  mpm_pkg::mpm_out_t skid;
  logic              skid_valid;
  logic              pop;

  assign pop  = res_valid && res_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !res_valid) begin
        if (skid_valid) begin
          res_data   <= skid;
          res_valid  <= 1'b1;
          skid_valid <= push;
          if (push) begin
            skid <= push_data;
          end
        end else begin
          res_valid <= push;
          if (push) begin
            res_data <= push_data;
          end
        end
      end else if (push) begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/multi_period_meter_with_timeout.sv
// Each result is registered in the output register, or the skid register if that is held.
// Throughput: one item per cycle while results are taken; one result can wait in the
// output register and one more in the skid register before req_ready drops.
// Reset (rst, synchronous, active high) returns the meter to idle, clears both output
// registers and loads the configuration registers with their default values.
module multi_period_meter_with_timeout #(
  parameter int COUNT_BITS = mpm_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Tick items: one per timer tick, with a start request and the pin sample.
  input  logic                          req_valid,
  output logic                          req_ready,
  input  mpm_pkg::mpm_in_t              req_data,
  // Measurement results.
  output logic                          res_valid,
  input  logic                          res_ready,
  output mpm_pkg::mpm_out_t             res_data,
  // Configuration writes; the meter uses the new values from the next item on,
  // even in the middle of a measurement.
  input  logic                          cfg_we,
  input  logic [mpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpm_pkg::CFG_W-1:0]     cfg_data
);

  mpm_pkg::mpm_cfg_t cfg;
  mpm_pkg::mpm_out_t core_result;
  logic              core_push;
  logic              take;

  // The skid register being empty guarantees a place for any result this item makes,
  // so ready never depends on res_ready in the same cycle.
  assign take = req_valid && req_ready;

  mpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Phase tracking, tick counting, timeout and metal compares; one item per cycle if ready.
  mpm_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (req_data),
    .cfg    (cfg),
    .push   (core_push),
    .result (core_result)
  );

  // Output register plus skid stage, so the meter keeps taking ticks until both are full.
  mpm_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (core_push),
    .push_data (core_result),
    .room      (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

FILE: rtl/core/mpm_checker.sv
module mpm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input mpm_pkg::mpm_in_t              req_data,
  input logic                          res_valid,
  input logic                          res_ready,
  input mpm_pkg::mpm_out_t             res_data
);

  // A held result must not change until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // A timeout carries no total and never flags metal.
  a_timeout: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.timed_out |-> res_data.period_ticks == '0 && !res_data.metal_found)
    else $error("timeout result carries data");

  // Reset empties the output stage.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A start item only arms the meter, so with nothing queued no result follows it.
  a_start: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.start_req && !res_valid |=> !res_valid)
    else $error("result after start item");

  // Input is held off only when results are queued.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid)
    else $error("ready low with no pending result");

endmodule

bind multi_period_meter_with_timeout mpm_checker u_mpm_checker (.*);

FILE: dv/tb_top.sv
module tb_top;

  localparam int COUNT_BITS  = mpm_pkg::COUNT_BITS_DEF;
  localparam int CYCLE_LIMIT = 500000;

  // Phases of a measurement as the checker tracks them.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK_LOW,
    ST_SEEK_HIGH,
    ST_CNT_LOW,
    ST_CNT_HIGH
  } meter_phase_t;

  localparam logic [COUNT_BITS:0]           TICK_SAT    = '1;
  localparam logic [COUNT_BITS:0]           REPORT_MAX  = {1'b0, {COUNT_BITS{1'b1}}};
  localparam logic [mpm_pkg::TIMEOUT_W-1:0] TIMEOUT_MAX = '1;
  localparam logic [mpm_pkg::LIMIT_W-1:0]   LIMIT_MAX   = '1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  mpm_pkg::mpm_in_t  req_data = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  mpm_pkg::mpm_out_t res_data;
  logic                          cfg_we = 1'b0;
  logic [mpm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mpm_pkg::CFG_W-1:0]     cfg_data = '0;

  multi_period_meter_with_timeout dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Local copy of the meter: configuration and measurement state.
  logic [mpm_pkg::PERIOD_W-1:0]  cfg_periods = mpm_pkg::PERIOD_COUNT_RST;
  logic [mpm_pkg::TIMEOUT_W-1:0] cfg_timeout = mpm_pkg::TIMEOUT_RST;
  logic [mpm_pkg::LIMIT_W-1:0]   cfg_metal   = mpm_pkg::METAL_LIMIT_RST;
  meter_phase_t                  ph = ST_IDLE;
  logic [COUNT_BITS:0]           ticks = '0;
  logic [mpm_pkg::PERIOD_W-1:0]  periods = '0;

  mpm_pkg::mpm_out_t expected_readings[$];
  mpm_pkg::mpm_out_t want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int items_sent = 0;
  int items_used = 0;
  int reg_writes = 0;
  int readings_seen = 0;
  int timeouts_seen = 0;
  int metal_seen = 0;

  // Closes a measurement: a timeout reports no total and never metal, a
  // finished one compares the unsaturated total with the metal limit.
  function automatic void queue_reading(input logic [COUNT_BITS:0] total, input logic to);
    mpm_pkg::mpm_out_t r;
    r.period_ticks = (total > REPORT_MAX) ? REPORT_MAX[mpm_pkg::TICKS_W-1:0]
                                          : total[mpm_pkg::TICKS_W-1:0];
    r.timed_out    = to;
    r.metal_found  = !to && (total < {1'b0, cfg_metal});
    expected_readings.push_back(r);
    ph      = ST_IDLE;
    ticks   = '0;
    periods = '0;
  endfunction

  // One timer tick through the meter.
  function automatic void meter_step(input mpm_pkg::mpm_in_t tick);
    logic level_ok;
    if (tick.start_req) begin
      // The start tick only arms the meter; its pin sample is ignored.
      items_used++;
      ph      = ST_SEEK_LOW;
      ticks   = '0;
      periods = '0;
      return;
    end
    if (ph == ST_IDLE) begin
      return;
    end
    items_used++;
    if (ticks != TICK_SAT) begin
      ticks = ticks + 1'b1;
    end
    level_ok = (ph == ST_SEEK_LOW || ph == ST_CNT_LOW) ? !tick.pin_level : tick.pin_level;
    if (level_ok) begin
      case (ph)
        ST_SEEK_LOW: begin
          ph    = ST_SEEK_HIGH;
          ticks = '0;
        end
        ST_SEEK_HIGH: begin
          // Rising edge opens the measure phase.
          ticks   = '0;
          periods = '0;
          if (cfg_periods == '0) begin
            queue_reading('0, 1'b0);
          end else begin
            ph = ST_CNT_LOW;
          end
        end
        ST_CNT_LOW: begin
          ph = ST_CNT_HIGH;
        end
        default: begin
          if (periods != '1) begin
            periods = periods + 1'b1;
          end
          // The live period count decides, even if it was lowered mid-measure.
          if (periods >= cfg_periods) begin
            queue_reading(ticks, 1'b0);
          end else begin
            ph = ST_CNT_LOW;
          end
        end
      endcase
    end else if (ticks > {1'b0, cfg_timeout}) begin
      queue_reading('0, 1'b1);
    end
  endfunction

  // Offers one item and returns at the falling edge after it is accepted.
  // Valid stays high so a following item goes out back to back.
  task automatic send_tick(input logic start, input logic pin);
    mpm_pkg::mpm_in_t item;
    item.start_req = start;
    item.pin_level = pin;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_data  = item;
    do begin
      @(posedge clk);
    end while (!req_ready);
    meter_step(item);
    items_sent++;
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected reading has come back.
  task automatic drain_readings();
    req_valid = 1'b0;
    while (expected_readings.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mpm_pkg::CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
    case (idx)
      mpm_pkg::REG_PERIOD_COUNT: cfg_periods = value[mpm_pkg::PERIOD_W-1:0];
      mpm_pkg::REG_TIMEOUT:      cfg_timeout = value[mpm_pkg::TIMEOUT_W-1:0];
      mpm_pkg::REG_METAL_LIMIT:  cfg_metal   = value[mpm_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Receiver: random back-pressure, or a forced hold-off while hold_left runs.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Every accepted reading is matched against the oldest one predicted.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_readings.size() == 0) begin
        $error("reading with none pending: period_ticks %0d timed_out %0b metal_found %0b",
               res_data.period_ticks, res_data.timed_out, res_data.metal_found);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        readings_seen++;
        if (res_data.timed_out) timeouts_seen++;
        if (res_data.metal_found) metal_seen++;
        if (res_data.period_ticks !== want.period_ticks) begin
          $error("period_ticks: expected %0d, got %0d", want.period_ticks,
                 res_data.period_ticks);
          fail_count++;
        end
        if (res_data.timed_out !== want.timed_out) begin
          $error("timed_out: expected %0b, got %0b", want.timed_out, res_data.timed_out);
          fail_count++;
        end
        if (res_data.metal_found !== want.metal_found) begin
          $error("metal_found: expected %0b, got %0b", want.metal_found,
                 res_data.metal_found);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d readings outstanding.",
               cycle_count, expected_readings.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Ticks with no start while idle must change nothing and report nothing.
  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_readings();
  endtask

  // With no periods to measure the meter reports as soon as the rising edge comes.
  task automatic test_zero_periods();
    write_reg(mpm_pkg::REG_PERIOD_COUNT, '0);
    write_reg(mpm_pkg::REG_METAL_LIMIT, mpm_pkg::CFG_W'(LIMIT_MAX));
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_readings();
  endtask

  // A zero limit aborts on the first tick without the awaited level; a limit
  // of one lets a single missing tick pass and aborts on the second.
  task automatic test_timeouts();
    write_reg(mpm_pkg::REG_PERIOD_COUNT, mpm_pkg::CFG_W'(1));
    write_reg(mpm_pkg::REG_TIMEOUT, '0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_readings();
    write_reg(mpm_pkg::REG_TIMEOUT, mpm_pkg::CFG_W'(1));
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    drain_readings();
  endtask

  // One full period; the low sample on the start tick must not count as the
  // low level being found.
  task automatic test_single_period();
    write_reg(mpm_pkg::REG_TIMEOUT, mpm_pkg::CFG_W'(TIMEOUT_MAX));
    write_reg(mpm_pkg::REG_METAL_LIMIT, mpm_pkg::CFG_W'(mpm_pkg::METAL_LIMIT_RST));
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_readings();
  endtask

  // The period count drops below the periods already done mid-measure; the
  // next completed period must end the measurement.
  task automatic test_period_change();
    write_reg(mpm_pkg::REG_PERIOD_COUNT, mpm_pkg::CFG_W'(10'h3FF));
    send_tick(1'b1, 1'b1);
    for (int i = 0; i < 3; i++) begin
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
    end
    drain_readings();
    write_reg(mpm_pkg::REG_PERIOD_COUNT, mpm_pkg::CFG_W'(1));
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_readings();
  endtask

  // The receiver stalls long enough for both output registers to fill while
  // readings keep coming, so the meter has to stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(mpm_pkg::REG_PERIOD_COUNT, '0);
    write_reg(mpm_pkg::REG_TIMEOUT, mpm_pkg::CFG_W'(5));
    write_reg(mpm_pkg::REG_METAL_LIMIT, mpm_pkg::CFG_W'($urandom_range(0, 1)));
    hold_left = 80;
    for (int i = 0; i < 10; i++) begin
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
    end
    drain_readings();
  endtask

  task automatic randomize_config();
    int pick;
    logic [mpm_pkg::CFG_W-1:0] value;
    pick  = $urandom_range(0, 19);
    value = (pick == 0) ? '0 : (pick == 1) ? mpm_pkg::CFG_W'(10'h3FF) :
            mpm_pkg::CFG_W'($urandom_range(1, 5));
    write_reg(mpm_pkg::REG_PERIOD_COUNT, value);
    pick  = $urandom_range(0, 19);
    value = (pick == 0) ? '0 : (pick == 1) ? mpm_pkg::CFG_W'(1) :
            (pick == 2) ? mpm_pkg::CFG_W'(TIMEOUT_MAX) :
            mpm_pkg::CFG_W'($urandom_range(3, 40));
    write_reg(mpm_pkg::REG_TIMEOUT, value);
    pick  = $urandom_range(0, 19);
    value = (pick == 0) ? '0 : (pick == 1) ? mpm_pkg::CFG_W'(LIMIT_MAX) :
            mpm_pkg::CFG_W'($urandom_range(0, 60));
    write_reg(mpm_pkg::REG_METAL_LIMIT, value);
  endtask

  // A start, then random-length square-wave runs; for six or fewer periods, long enough to
  // cover the configured periods. Occasional long runs provoke timeouts and
  // a rare start in the middle abandons the measurement.
  task automatic gen_measurement();
    logic level;
    int   runs;
    int   len;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    level = 1'($urandom_range(0, 1));
    runs  = 2 * ((cfg_periods > 6) ? 6 : int'(cfg_periods)) + $urandom_range(2, 5);
    for (int r = 0; r < runs; r++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 45) : $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        send_tick($urandom_range(0, 59) == 0, level);
      end
      level = ~level;
    end
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 12);
    for (int k = 0; k < n; k++) begin
      send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
    end
  endtask

  // Random traffic in batches; the registers are rewritten between batches
  // once the meter has returned every pending reading.
  task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int n_items);
    int stop_at;
    int batch_end;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      randomize_config();
      batch_end = items_sent + $urandom_range(60, 150);
      while (items_sent < batch_end) begin
        if ($urandom_range(0, 5) == 0) begin
          gen_noise();
        end else begin
          gen_measurement();
        end
      end
      drain_readings();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_idle_ticks();
    test_zero_periods();
    test_timeouts();
    test_single_period();
    test_period_change();
    test_backpressure();
    test_random_traffic(27, 50, 600);
    test_random_traffic(50, 27, 600);
    test_random_traffic(0, 0, 600);

    drain_readings();
    repeat (10) @(negedge clk);
    if (expected_readings.size() != 0) begin
      $error("%0d readings never arrived", expected_readings.size());
      fail_count++;
    end
    $display("Sent %0d ticks (%0d acted on) and %0d register writes; checked %0d readings.",
             items_sent, items_used, reg_writes, readings_seen);
    $display("Of those, %0d were timeouts and %0d flagged metal; %0d mismatches.",
             timeouts_seen, metal_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
